/* sv/tacs_pkg.sv */
// ----------------------------------------------------------------------------
// tacs_pkg
// Shared types and constants for the texture atlas column sampler.
// ----------------------------------------------------------------------------
package tacs_pkg;

  localparam int ATLAS_WORDS = 65536;
  localparam int ADDR_W      = $clog2(ATLAS_WORDS);
  localparam int DIV_STEPS   = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATLAS_WIDTH   = 3'd0,
    REG_TILE_WIDTH    = 3'd1,
    REG_TILE_HEIGHT   = 3'd2,
    REG_TILES_PER_ROW = 3'd3,
    REG_TILE_COUNT    = 3'd4
  } reg_idx_t;

  localparam logic [10:0] RST_ATLAS_WIDTH   = 11'd256;
  localparam logic [8:0]  RST_TILE_WIDTH    = 9'd64;
  localparam logic [8:0]  RST_TILE_HEIGHT   = 9'd64;
  localparam logic [8:0]  RST_TILES_PER_ROW = 9'd4;
  localparam logic [8:0]  RST_TILE_COUNT    = 9'd16;

  typedef struct packed {
    logic [10:0] atlas_width;
    logic [8:0]  tile_width;
    logic [8:0]  tile_height;
    logic [8:0]  tiles_per_row;
    logic [8:0]  tile_count;
  } cfg_t;

  // travels with every item down the pipe
  typedef struct packed {
    logic        valid;
    logic        op;
    logic        err;
    logic [15:0] waddr;
    logic [31:0] wdata;
    logic [7:0]  col;
  } tag_t;

  typedef struct packed {
    tag_t       tag;
    logic [8:0] tx;
    logic [8:0] ty;
    logic [8:0] rowt;
  } div_out_t;

  typedef struct packed {
    logic [31:0] texel;
    logic        oor;
  } res_t;

endpackage

/* sv/tacs_ram.sv */
// ----------------------------------------------------------------------------
// tacs_ram
// Generic single-port RAM, registered read, read and write gated by en.
// ----------------------------------------------------------------------------
module tacs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/tacs_div_pipe.sv */
// ----------------------------------------------------------------------------
// tacs_div_pipe
// Two restoring dividers in lockstep, one quotient bit per stage:
// tile / tiles_per_row and (row * tile_height) / draw_height.
// ----------------------------------------------------------------------------
module tacs_div_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tacs_pkg::cfg_t     cfg,
  input  tacs_pkg::tag_t     in_tag,
  input  logic [7:0]         in_tile,
  input  logic [11:0]        in_height,
  input  logic [19:0]        in_prod,
  output tacs_pkg::div_out_t dout
);
  import tacs_pkg::*;

  typedef struct packed {
    tag_t        tag;
    logic [11:0] height;
    logic [8:0]  rem_a;
    logic [8:0]  dq_a;
    logic [11:0] rem_b;
    logic [8:0]  dq_b;
  } dstage_t;

  dstage_t st_r [DIV_STEPS];
  dstage_t init;

  // quotient of the row scale is below 2^9 for any legal item, so the
  // top dividend bits start as the partial remainder
  always_comb begin
    init.tag    = in_tag;
    init.height = in_height;
    init.rem_a  = '0;
    init.dq_a   = {1'b0, in_tile};
    init.rem_b  = {1'b0, in_prod[19:9]};
    init.dq_b   = in_prod[8:0];
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    dstage_t    cur;
    dstage_t    st_nxt;
    logic [9:0]  ta;
    logic [12:0] tb;
    logic        qa;
    logic        qb;

    if (k == 0) begin : g_first
      assign cur = init;
    end else begin : g_rest
      assign cur = st_r[k-1];
    end

    always_comb begin
      st_nxt = cur;
      ta = {cur.rem_a, cur.dq_a[8]};
      tb = {cur.rem_b, cur.dq_b[8]};
      qa = (ta >= {1'b0, cfg.tiles_per_row});
      qb = (tb >= {1'b0, cur.height});
      if (qa) begin
        st_nxt.rem_a = 9'(ta - {1'b0, cfg.tiles_per_row});
      end else begin
        st_nxt.rem_a = ta[8:0];
      end
      if (qb) begin
        st_nxt.rem_b = 12'(tb - {1'b0, cur.height});
      end else begin
        st_nxt.rem_b = tb[11:0];
      end
      st_nxt.dq_a = {cur.dq_a[7:0], qa};
      st_nxt.dq_b = {cur.dq_b[7:0], qb};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].tag.valid <= 1'b0;
      end else if (en) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  always_comb begin
    dout.tag  = st_r[DIV_STEPS-1].tag;
    dout.tx   = st_r[DIV_STEPS-1].rem_a;
    dout.ty   = st_r[DIV_STEPS-1].dq_a;
    dout.rowt = st_r[DIV_STEPS-1].dq_b;
  end

endmodule

/* sv/tacs_addr_pipe.sv */
// ----------------------------------------------------------------------------
// tacs_addr_pipe
// Atlas address arithmetic, range checks and the atlas store access.
// ----------------------------------------------------------------------------
module tacs_addr_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tacs_pkg::cfg_t     cfg,
  input  tacs_pkg::div_out_t din,
  output logic               push,
  output tacs_pkg::res_t     res
);
  import tacs_pkg::*;

  tag_t        m1_tag_r;
  logic [17:0] m1_mx_r;
  logic [17:0] m1_my_r;
  logic [8:0]  m1_rowt_r;

  tag_t        m2_tag_r;
  tag_t        m2_tag_nxt;
  logic [18:0] m2_x_nxt;
  logic [18:0] m2_x_r;
  logic [18:0] m2_y_r;

  tag_t        m3_tag_r;
  logic [29:0] m3_py_r;
  logic [18:0] m3_x_r;

  logic [30:0] addr;
  logic        addr_err;
  logic        wr_ok;
  logic        ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0] ram_rdata;

  logic        m4_valid_r;
  logic        m4_op_r;
  logic        m4_err_r;

  always_comb begin
    m2_x_nxt   = 19'(m1_mx_r) + 19'(m1_tag_r.col);
    m2_tag_nxt = m1_tag_r;
    m2_tag_nxt.err = m1_tag_r.err || (m2_x_nxt >= 19'(cfg.atlas_width));
  end

  always_comb begin
    addr     = 31'(m3_py_r) + 31'(m3_x_r);
    addr_err = addr >= 31'(ATLAS_WORDS);
    wr_ok    = 32'(m3_tag_r.waddr) < 32'(ATLAS_WORDS);
    ram_we   = en && m3_tag_r.valid && (m3_tag_r.op == OP_WRITE) && wr_ok;
    if (m3_tag_r.op == OP_WRITE) begin
      ram_addr = ADDR_W'(m3_tag_r.waddr);
    end else begin
      ram_addr = ADDR_W'(addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_tag_r.valid <= 1'b0;
      m2_tag_r.valid <= 1'b0;
      m3_tag_r.valid <= 1'b0;
      m4_valid_r     <= 1'b0;
    end else if (en) begin
      m1_tag_r   <= din.tag;
      m1_mx_r    <= 18'(din.tx) * 18'(cfg.tile_width);
      m1_my_r    <= 18'(din.ty) * 18'(cfg.tile_height);
      m1_rowt_r  <= din.rowt;
      m2_tag_r   <= m2_tag_nxt;
      m2_x_r     <= m2_x_nxt;
      m2_y_r     <= 19'(m1_my_r) + 19'(m1_rowt_r);
      m3_tag_r   <= m2_tag_r;
      m3_py_r    <= 30'(m2_y_r) * 30'(cfg.atlas_width);
      m3_x_r     <= m2_x_r;
      m4_valid_r <= m3_tag_r.valid;
      m4_op_r    <= m3_tag_r.op;
      m4_err_r   <= m3_tag_r.err || addr_err;
    end
  end

  tacs_ram #(
    .WIDTH(32),
    .DEPTH(ATLAS_WORDS)
  ) u_atlas (
    .clk  (clk),
    .en   (en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(m3_tag_r.wdata),
    .rdata(ram_rdata)
  );

  assign push      = en && m4_valid_r && (m4_op_r == OP_SAMPLE);
  assign res.texel = m4_err_r ? '0 : ram_rdata;
  assign res.oor   = m4_err_r;

endmodule

/* sv/tacs_out_buf.sv */
// ----------------------------------------------------------------------------
// tacs_out_buf
// Two-entry result buffer; parts the pipeline from the result channel.
// ----------------------------------------------------------------------------
module tacs_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tacs_pkg::res_t push_data,
  input  logic           pop,
  output logic           out_vld,
  output tacs_pkg::res_t out_data,
  output logic           full
);
  import tacs_pkg::*;

  res_t       head_r;
  res_t       tail_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign out_vld  = (cnt_r != 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign out_data = head_r;
  assign do_pop   = pop && out_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && do_pop) begin
      if (cnt_r == 2'd1) begin
        head_r <= push_data;
      end else begin
        head_r <= tail_r;
        tail_r <= push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_r <= push_data;
      end else begin
        tail_r <= push_data;
      end
    end else if (do_pop) begin
      head_r <= tail_r;
    end
  end

endmodule

/* sv/texture_atlas_column_sampler_unit.sv */
// ----------------------------------------------------------------------------
// texture_atlas_column_sampler_unit
// Nearest-neighbour texel sampler over a tiled atlas held in on-chip RAM.
// ----------------------------------------------------------------------------
// Takes one transfer per clock while in_ready is high, write or sample. A
// sample is loaded by the accepting edge into the input check/multiply
// stage. It then goes through nine divider stages producing one quotient bit
// each for the tile position and the row scale, three multiply and add stages,
// the registered read of the single-port atlas RAM and the result buffer. Writes
// and samples reach the RAM in the order taken, so a sample sees every earlier
// write. in_ready falls only when the two-entry result buffer is full. Atlas
// words are undefined until written; there is no clearing pass after reset.
module texture_atlas_column_sampler_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tacs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tacs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [15:0]                      in_store_address,
  input  logic [31:0]                      in_texel_in,
  input  logic [7:0]                       in_tile_index,
  input  logic [7:0]                       in_column_in_tile,
  input  logic [11:0]                      in_draw_height,
  input  logic [10:0]                      in_screen_row,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      out_texel_out,
  output logic                             out_out_of_range
);
  import tacs_pkg::*;

  cfg_t        cfg_r;
  logic        en;
  logic        ob_full;

  tag_t        s0_tag_nxt;
  tag_t        s0_tag_r;
  logic [7:0]  s0_tile_r;
  logic [11:0] s0_height_r;
  logic [19:0] s0_prod_r;

  div_out_t    div_out;
  logic        res_push;
  res_t        res;
  res_t        ob_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.atlas_width   <= RST_ATLAS_WIDTH;
      cfg_r.tile_width    <= RST_TILE_WIDTH;
      cfg_r.tile_height   <= RST_TILE_HEIGHT;
      cfg_r.tiles_per_row <= RST_TILES_PER_ROW;
      cfg_r.tile_count    <= RST_TILE_COUNT;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ATLAS_WIDTH:   cfg_r.atlas_width   <= cfg_data;
        REG_TILE_WIDTH:    cfg_r.tile_width    <= cfg_data[8:0];
        REG_TILE_HEIGHT:   cfg_r.tile_height   <= cfg_data[8:0];
        REG_TILES_PER_ROW: cfg_r.tiles_per_row <= cfg_data[8:0];
        REG_TILE_COUNT:    cfg_r.tile_count    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign en       = !ob_full;
  assign in_ready = en;

  always_comb begin
    s0_tag_nxt.valid = in_valid;
    s0_tag_nxt.op    = in_operation;
    s0_tag_nxt.waddr = in_store_address;
    s0_tag_nxt.wdata = in_texel_in;
    s0_tag_nxt.col   = in_column_in_tile;
    s0_tag_nxt.err   = (cfg_r.atlas_width == '0) || (cfg_r.tile_width == '0) ||
                       (cfg_r.tile_height == '0) || (cfg_r.tiles_per_row == '0) ||
                       ({1'b0, in_tile_index} >= cfg_r.tile_count) ||
                       ({1'b0, in_column_in_tile} >= cfg_r.tile_width) ||
                       (in_draw_height == '0) ||
                       ({1'b0, in_screen_row} >= in_draw_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_tag_r.valid <= 1'b0;
    end else if (en) begin
      s0_tag_r    <= s0_tag_nxt;
      s0_tile_r   <= in_tile_index;
      s0_height_r <= in_draw_height;
      s0_prod_r   <= 20'(in_screen_row) * 20'(cfg_r.tile_height);
    end
  end

  tacs_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .in_tag   (s0_tag_r),
    .in_tile  (s0_tile_r),
    .in_height(s0_height_r),
    .in_prod  (s0_prod_r),
    .dout     (div_out)
  );

  tacs_addr_pipe u_addr (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .cfg  (cfg_r),
    .din  (div_out),
    .push (res_push),
    .res  (res)
  );

  tacs_out_buf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res),
    .pop      (out_ready),
    .out_vld  (out_valid),
    .out_data (ob_data),
    .full     (ob_full)
  );

  assign out_texel_out    = ob_data.texel;
  assign out_out_of_range = ob_data.oor;

`ifndef NO_ASSERTIONS
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_err_zero_texel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_texel_out == '0)
    else $error("error result carries a non-zero texel");

  a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(res_push))
    else $error("result appeared without a pipeline push");
`endif

endmodule
